// File: sv/crp_pkg.sv
`timescale 1ns / 1ps
package crp_pkg;
   localparam int MaxPoints = 256;
   localparam int FracBits = 16;
   localparam int IdxW = $clog2(MaxPoints);
   localparam int CntW = IdxW + 1;
   localparam int CoordW = 32;
   localparam int CoefW = CoordW + 4;
   localparam int ProdW = CoefW + FracBits + 1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_EVAL = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_FULL = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_STORE,
      OP_COPY,
      OP_SPLINE
   } op_type;

   typedef struct packed {
      op_type op;
      status_type status;
      logic [CntW-1:0] held;
      logic [IdxW-1:0] wr_idx;
      logic [IdxW-1:0] i0;
      logic [IdxW-1:0] i1;
      logic [IdxW-1:0] i2;
      logic [IdxW-1:0] i3;
      logic [CoordW-1:0] px;
      logic [CoordW-1:0] py;
      logic [CoordW-1:0] pz;
      logic [FracBits-1:0] frac;
   } task_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_SUM,
      BK_OUT
   } back_state_type;
endpackage

// File: sv/crp_if.sv
`timescale 1ns / 1ps
interface crp_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [7:0] point_index;
   logic signed [31:0] px;
   logic signed [31:0] py;
   logic signed [31:0] pz;
   logic [23:0] t_param;
   modport source (output valid, cmd, point_index, px, py, pz, t_param, input ready);
   modport sink (input valid, cmd, point_index, px, py, pz, t_param, output ready);
endinterface

interface crp_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [1:0] status;
   logic [8:0] points_held;
   modport source (output valid, pos_x, pos_y, pos_z, status, points_held, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, status, points_held, output ready);
endinterface

// File: sv/crp_ram.sv
`timescale 1ns / 1ps
module crp_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: sv/crp_front.sv
`timescale 1ns / 1ps
module crp_front import crp_pkg::*; (
   input logic clock,
   input logic reset,
   crp_req_if.sink req,
   output logic q_valid,
   input logic q_ready,
   output task_type q_task
);
   logic [CntW-1:0] held_ff, held_in;
   logic valid_ff, valid_in;
   task_type task_ff, task_in;
   logic take;
   logic [CntW-1:0] last;
   logic [IdxW-1:0] seg;
   logic [CntW-1:0] seg_w;

   // A single-entry queue decouples classification from the datapath.
   assign req.ready = !valid_ff || q_ready;
   assign take = req.valid && req.ready;
   assign q_valid = valid_ff;
   assign q_task = task_ff;
   assign last = held_ff - 1'b1;
   assign seg = req.t_param[FracBits +: IdxW];
   assign seg_w = {1'b0, seg};

   always_comb begin
      task_in = task_ff;
      held_in = held_ff;
      valid_in = valid_ff && !q_ready;
      if (take) begin
         valid_in = 1'b1;
         task_in.op = OP_NONE;
         task_in.status = ST_OK;
         task_in.px = req.px;
         task_in.py = req.py;
         task_in.pz = req.pz;
         task_in.frac = req.t_param[FracBits-1:0];
         task_in.wr_idx = req.point_index;
         task_in.i0 = last[IdxW-1:0];
         task_in.i1 = last[IdxW-1:0];
         task_in.i2 = last[IdxW-1:0];
         task_in.i3 = last[IdxW-1:0];
         case (cmd_type'(req.cmd))
            CMD_CLEAR: begin
               held_in = '0;
            end
            CMD_APPEND: begin
               if (held_ff >= CntW'(MaxPoints)) begin
                  task_in.status = ST_FULL;
               end else begin
                  task_in.op = OP_STORE;
                  task_in.wr_idx = held_ff[IdxW-1:0];
                  held_in = held_ff + 1'b1;
               end
            end
            CMD_WRITE: begin
               if ({1'b0, req.point_index} >= held_ff) begin
                  task_in.status = ST_RANGE;
               end else begin
                  task_in.op = OP_STORE;
               end
            end
            default: begin
               if (held_ff == '0) begin
                  task_in.status = ST_EMPTY;
               end else if (req.t_param[23:FracBits] >= 8'(last)
                            || seg_w >= last) begin
                  task_in.op = OP_COPY;
               end else begin
                  task_in.op = OP_SPLINE;
                  task_in.i1 = seg;
                  task_in.i0 = (seg == '0) ? seg : seg - 1'b1;
                  task_in.i2 = seg + 1'b1;
                  task_in.i3 = (seg_w + 2'd2 > last) ? last[IdxW-1:0] : seg + 2'd2;
               end
            end
         endcase
         task_in.held = held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         valid_ff <= valid_in;
      end
      task_ff <= task_in;
   end
endmodule

// File: sv/crp_back.sv
`timescale 1ns / 1ps
module crp_back import crp_pkg::*; (
   input logic clock,
   input logic reset,
   input logic q_valid,
   output logic q_ready,
   input task_type q_task,
   crp_rsp_if.source rsp
);
   back_state_type state_ff, state_in;
   task_type task_ff;
   logic [1:0] rd_cnt_ff, rd_cnt_in;
   logic [2:0] cap_cnt_ff, cap_cnt_in;
   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] wr_addr;
   logic wr_en;
   logic [CoordW-1:0] rd_x, rd_y, rd_z;
   logic signed [CoordW-1:0] px_ff [4];
   logic signed [CoordW-1:0] py_ff [4];
   logic signed [CoordW-1:0] pz_ff [4];
   logic [FracBits-1:0] f2_ff, f3_ff;
   logic [2*FracBits-1:0] f2_full, f3_full;
   logic signed [63:0] acc_ff [3];
   logic signed [CoordW-1:0] res_ff [3];
   logic signed [63:0] sum_w [3];
   logic signed [CoordW-1:0] sat_w [3];
   logic signed [CoefW-1:0] p_w [3][4];
   logic signed [CoefW-1:0] ca_w [3], cb_w [3], cc_w [3], cd_w [3];
   logic signed [CoefW-1:0] ca_ff [3], cb_ff [3], cc_ff [3], cd_ff [3];
   logic signed [ProdW-1:0] pb_w [3], pc_w [3], pd_w [3];
   logic load, take_out;

   assign take_out = rsp.valid && rsp.ready;
   assign q_ready = (state_ff == BK_IDLE);
   assign load = q_valid && q_ready;
   assign wr_en = load && (q_task.op == OP_STORE);
   assign wr_addr = q_task.wr_idx;

   always_comb begin
      case (rd_cnt_ff)
         2'd0: rd_addr = task_ff.i0;
         2'd1: rd_addr = task_ff.i1;
         2'd2: rd_addr = task_ff.i2;
         default: rd_addr = task_ff.i3;
      endcase
   end

   crp_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(q_task.px),
      .rd_addr(rd_addr), .rd_data(rd_x));
   crp_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(q_task.py),
      .rd_addr(rd_addr), .rd_data(rd_y));
   crp_ram #(.Width(CoordW), .Depth(MaxPoints)) u_ram_z (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(q_task.pz),
      .rd_addr(rd_addr), .rd_data(rd_z));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (load) begin
               state_in = (q_task.op == OP_COPY || q_task.op == OP_SPLINE) ? BK_READ : BK_OUT;
            end
         end
         BK_READ: begin
            if (cap_cnt_ff == 3'd4 || (task_ff.op == OP_COPY && cap_cnt_ff == 3'd1)) begin
               state_in = (task_ff.op == OP_COPY) ? BK_OUT : BK_MUL;
            end
         end
         BK_MUL: state_in = BK_SUM;
         BK_SUM: state_in = BK_OUT;
         BK_OUT: begin
            if (take_out) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      rd_cnt_in = rd_cnt_ff;
      cap_cnt_in = cap_cnt_ff;
      if (load) begin
         rd_cnt_in = '0;
         cap_cnt_in = '0;
      end else if (state_ff == BK_READ) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         cap_cnt_in = cap_cnt_ff + 1'b1;
      end
   end

   // A read issued in one cycle returns in the next, so each capture stores the read issued before it.
   assign f2_full = task_ff.frac * task_ff.frac;
   assign f3_full = f2_ff * task_ff.frac;

   // The cubic coefficients are formed in one cycle and weighted in the next.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         p_w[0][j] = CoefW'(px_ff[j]);
         p_w[1][j] = CoefW'(py_ff[j]);
         p_w[2][j] = CoefW'(pz_ff[j]);
      end
      for (int k = 0; k < 3; k++) begin
         ca_w[k] = p_w[k][1] <<< 1;
         cb_w[k] = p_w[k][2] - p_w[k][0];
         cc_w[k] = (p_w[k][0] <<< 1) - ((p_w[k][1] <<< 2) + p_w[k][1])
                   + (p_w[k][2] <<< 2) - p_w[k][3];
         cd_w[k] = ((p_w[k][1] <<< 1) + p_w[k][1]) - ((p_w[k][2] <<< 1) + p_w[k][2])
                   + p_w[k][3] - p_w[k][0];
         pb_w[k] = cb_ff[k] * $signed({1'b0, task_ff.frac});
         pc_w[k] = cc_ff[k] * $signed({1'b0, f2_ff});
         pd_w[k] = cd_ff[k] * $signed({1'b0, f3_ff});
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum_w[k] = acc_ff[k] >>> 1;
         if (sum_w[k] > 64'sd2147483647) begin
            sat_w[k] = 32'sh7fffffff;
         end else if (sum_w[k] < -64'sd2147483648) begin
            sat_w[k] = 32'sh80000000;
         end else begin
            sat_w[k] = sum_w[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rd_cnt_ff <= '0;
         cap_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         cap_cnt_ff <= cap_cnt_in;
      end
      if (load) begin
         task_ff <= q_task;
      end
      if (state_ff == BK_READ && cap_cnt_ff != 3'd0) begin
         px_ff[cap_cnt_ff[1:0] - 2'd1] <= rd_x;
         py_ff[cap_cnt_ff[1:0] - 2'd1] <= rd_y;
         pz_ff[cap_cnt_ff[1:0] - 2'd1] <= rd_z;
         if (task_ff.op == OP_COPY) begin
            res_ff[0] <= rd_x;
            res_ff[1] <= rd_y;
            res_ff[2] <= rd_z;
         end
      end
      if (state_ff == BK_READ) begin
         f2_ff <= f2_full[2*FracBits-1:FracBits];
      end
      if (state_ff == BK_MUL) begin
         f3_ff <= f3_full[2*FracBits-1:FracBits];
         for (int k = 0; k < 3; k++) begin
            ca_ff[k] <= ca_w[k];
            cb_ff[k] <= cb_w[k];
            cc_ff[k] <= cc_w[k];
            cd_ff[k] <= cd_w[k];
         end
      end
      if (state_ff == BK_SUM) begin
         for (int k = 0; k < 3; k++) begin
            acc_ff[k] <= 64'(ca_ff[k]) + 64'(pb_w[k] >>> FracBits)
                         + 64'(pc_w[k] >>> FracBits) + 64'(pd_w[k] >>> FracBits);
         end
      end
   end

   logic out_sat_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_sat_ff <= 1'b0;
      end else if (state_ff == BK_SUM) begin
         out_sat_ff <= 1'b1;
      end else if (load) begin
         out_sat_ff <= 1'b0;
      end
   end

   assign rsp.valid = (state_ff == BK_OUT);
   assign rsp.status = task_ff.status;
   assign rsp.points_held = task_ff.held;
   assign rsp.pos_x = out_sat_ff ? sat_w[0] : (task_ff.op == OP_COPY ? res_ff[0] : '0);
   assign rsp.pos_y = out_sat_ff ? sat_w[1] : (task_ff.op == OP_COPY ? res_ff[1] : '0);
   assign rsp.pos_z = out_sat_ff ? sat_w[2] : (task_ff.op == OP_COPY ? res_ff[2] : '0);
endmodule

// File: sv/catmull_rom_path_eval.sv
`timescale 1ns / 1ps
// Table commands are answered without a memory read; an evaluation at or past
// the last point reads that point once, and one between points reads four
// points serially from the single-read-port coordinate memories and then
// passes the cubic stages; the next request waits until the response is taken.
// Reset (synchronous, active high) empties the table and the queue;
// memory contents are left as they are.
module catmull_rom_path_eval import crp_pkg::*; (
   input logic clock,
   input logic reset,
   crp_req_if.sink req,
   crp_rsp_if.source rsp
);
   logic q_valid, q_ready;
   task_type q_task;

   crp_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task));

   crp_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_task(q_task), .rsp(rsp));
endmodule

// File: tb/tb_catmull_rom_path_eval.sv
`timescale 1ns / 1ps
module tb_catmull_rom_path_eval;
   import crp_pkg::*;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      status_type st;
      logic [8:0] held;
   } path_result_type;

   // Predicts the block's answers from its own copy of the point table.
   class path_scoreboard;
      logic signed [31:0] tab_x [MaxPoints];
      logic signed [31:0] tab_y [MaxPoints];
      logic signed [31:0] tab_z [MaxPoints];
      int unsigned held_n;
      path_result_type pending [$];
      int errors;
      int evals_ok;

      function logic signed [31:0] curve_axis(logic signed [31:0] q0,
            logic signed [31:0] q1, logic signed [31:0] q2, logic signed [31:0] q3,
            longint f, longint f2, longint f3);
         longint p0, p1, p2, p3, a, b, c, d, s;
         p0 = q0; p1 = q1; p2 = q2; p3 = q3;
         a = 2 * p1;
         b = p2 - p0;
         c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
         d = -p0 + 3 * p1 - 3 * p2 + p3;
         s = a + ((b * f) >>> FracBits) + ((c * f2) >>> FracBits)
             + ((d * f3) >>> FracBits);
         s = s >>> 1;
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         return s[31:0];
      endfunction

      function void note_request(cmd_type cmd, logic [7:0] idx, logic signed [31:0] x,
            logic signed [31:0] y, logic signed [31:0] z, logic [23:0] t);
         path_result_type r;
         int unsigned seg, last, i0, i1, i2, i3;
         longint f, f2, f3;
         r.x = 0; r.y = 0; r.z = 0; r.st = ST_OK;
         case (cmd)
            CMD_CLEAR: held_n = 0;
            CMD_APPEND: begin
               if (held_n >= MaxPoints) begin
                  r.st = ST_FULL;
               end else begin
                  tab_x[held_n] = x; tab_y[held_n] = y; tab_z[held_n] = z;
                  held_n++;
               end
            end
            CMD_WRITE: begin
               if (idx >= held_n) begin
                  r.st = ST_RANGE;
               end else begin
                  tab_x[idx] = x; tab_y[idx] = y; tab_z[idx] = z;
               end
            end
            default: begin
               if (held_n == 0) begin
                  r.st = ST_EMPTY;
               end else begin
                  seg = 32'(t[23:FracBits]);
                  last = held_n - 1;
                  if (seg >= last) begin
                     r.x = tab_x[last]; r.y = tab_y[last]; r.z = tab_z[last];
                  end else begin
                     i1 = seg;
                     i0 = (i1 > 0) ? i1 - 1 : 0;
                     i2 = i1 + 1;
                     i3 = (i1 + 2 > last) ? last : i1 + 2;
                     f = 64'(t[FracBits-1:0]);
                     f2 = (f * f) >>> FracBits;
                     f3 = (f2 * f) >>> FracBits;
                     r.x = curve_axis(tab_x[i0], tab_x[i1], tab_x[i2], tab_x[i3], f, f2, f3);
                     r.y = curve_axis(tab_y[i0], tab_y[i1], tab_y[i2], tab_y[i3], f, f2, f3);
                     r.z = curve_axis(tab_z[i0], tab_z[i1], tab_z[i2], tab_z[i3], f, f2, f3);
                     evals_ok++;
                  end
               end
            end
         endcase
         r.held = 9'(held_n);
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(logic signed [31:0] x, logic signed [31:0] y,
            logic signed [31:0] z, logic [1:0] st, logic [8:0] held);
         path_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (x !== e.x) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, e.x, x);
            errors++;
         end
         if (y !== e.y) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, e.y, y);
            errors++;
         end
         if (z !== e.z) begin
            $display("%0t: pos_z expected %0d actual %0d", $time, e.z, z);
            errors++;
         end
         if (st !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            errors++;
         end
         if (held !== e.held) begin
            $display("%0t: points_held expected %0d actual %0d", $time, e.held, held);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   crp_req_if req ();
   crp_rsp_if rsp ();
   path_scoreboard board;
   bit quiet_tail;
   int idle_cycles;
   int sent;

   catmull_rom_path_eval u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            board.note_request(cmd_type'(req.cmd), req.point_index, req.px, req.py,
                               req.pz, req.t_param);
         end
         if (rsp.valid && rsp.ready) begin
            board.check_result(rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.status,
                               rsp.points_held);
         end
      end
   end

   // The receiver stalls in random bursts until the final stretch.
   initial begin : rsp_stall
      int n;
      rsp.ready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            rsp.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(cmd_type cmd, logic [7:0] idx, logic signed [31:0] x,
         logic signed [31:0] y, logic signed [31:0] z, logic [23:0] t);
      int n;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 8);
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.point_index <= idx;
      req.px <= x;
      req.py <= y;
      req.pz <= z;
      req.t_param <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_random(int unsigned held_guess);
      cmd_type c;
      logic [23:0] t;
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) c = CMD_CLEAR;
      else if (r < 30) c = CMD_APPEND;
      else if (r < 45) c = CMD_WRITE;
      else c = CMD_EVAL;
      t = 24'($urandom());
      if ($urandom_range(0, 3) != 0 && held_guess > 1)
         t[23:16] = 8'($urandom_range(0, held_guess - 1));
      send_request(c, 8'($urandom_range(0, 3) == 0 ? $urandom() :
                   $urandom_range(0, held_guess)), any_coord(), any_coord(),
                   any_coord(), t);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int i;
      board = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.cmd = CMD_CLEAR;
      req.point_index = '0;
      req.px = '0;
      req.py = '0;
      req.pz = '0;
      req.t_param = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, bad overwrites, a single point, curves.
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'hffffff);
      send_request(CMD_WRITE, 8'd0, 1, 2, 3, 24'd0);
      send_request(CMD_APPEND, 8'd0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 24'd0);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h00ffff);
      send_request(CMD_APPEND, 8'd0, 32'sh80000000, 32'sh7fffffff, -32'sh00030000, 24'd0);
      send_request(CMD_APPEND, 8'd0, 32'sh7fffffff, 32'sh80000000, 32'sh00050000, 24'd0);
      send_request(CMD_APPEND, 8'd0, 32'sh80000000, 32'sh7fffffff, 32'sh00000000, 24'd0);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h008000);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h01ffff);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h024000);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h030000);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'hff0000);
      send_request(CMD_WRITE, 8'd3, 32'sh00020000, 1, -1, 24'd0);
      send_request(CMD_WRITE, 8'd4, 0, 0, 0, 24'd0);
      send_request(CMD_WRITE, 8'd255, 0, 0, 0, 24'd0);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'h02ffff);
      send_request(CMD_CLEAR, 8'd0, 0, 0, 0, 24'd0);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'd0);
      drain();

      // Fill the table to the top, then try to append past it.
      for (i = 0; i < MaxPoints + 2; i++)
         send_request(CMD_APPEND, 8'd0, any_coord(), any_coord(), any_coord(), 24'd0);
      send_request(CMD_WRITE, 8'd255, any_coord(), any_coord(), any_coord(), 24'd0);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'hfe8000);
      send_request(CMD_EVAL, 8'd0, 0, 0, 0, 24'hffffff);
      drain();
      send_request(CMD_CLEAR, 8'd0, 0, 0, 0, 24'd0);

      // Random part on small tables, cleared every now and then.
      for (i = 0; i < 680; i++) begin
         if (i % 100 == 99) begin
            send_request(CMD_CLEAR, 8'd0, 0, 0, 0, 24'd0);
            if (i == 299) drain();
         end
         if (i > 560) quiet_tail = 1'b1;
         send_random(board.held_n);
      end
      drain();
      repeat (30) @(posedge clock);
      $display("Sent %0d requests including a full table and %0d interpolated evaluations.",
               sent, board.evals_ok);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
